// ===== hdl/line_break_dp_unit_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef LINE_BREAK_DP_UNIT_MACROS_SVH
`define LINE_BREAK_DP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define LBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is held.
`define LBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lbd_pkg.sv =====
package lbd_pkg;

	localparam int MAX_WORDS  = 64;
	localparam int WIDTH_BITS = 16;

	localparam int IDX_W      = $clog2(MAX_WORDS);
	localparam int CNT_W      = $clog2(MAX_WORDS + 1);
	localparam int WORD_W     = 16;
	localparam int PAGE_W     = 16;
	localparam int SPACE_W    = 10;
	localparam int LEN_W      = ((WIDTH_BITS > PAGE_W) ? WIDTH_BITS : PAGE_W) + 2;
	localparam int REM_W      = PAGE_W;
	localparam int SQ_W       = 2 * REM_W;
	localparam int COST_W     = 31;
	localparam int LINE_END_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [COST_W-1:0]  COST_CAP    = {COST_W{1'b1}};
	localparam logic [PAGE_W-1:0]  PAGE_RESET  = PAGE_W'(480);
	localparam logic [SPACE_W-1:0] SPACE_RESET = SPACE_W'(8);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH = CFG_IDX_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD,
		ST_LEN,
		ST_SQ,
		ST_ACC,
		ST_WR,
		ST_TRD,
		ST_TCALC,
		ST_OUT
	} lbd_state_t;

endpackage

// ===== hdl/line_break_dp_unit.sv =====
// Minimum-raggedness line breaker for one paragraph.
// Input channel (in_valid/in_ready): one beat per word, word_width plus
// last_word. Beats are stored in order; last_word closes the paragraph.
// Output channel (out_valid/out_ready): one beat per line, in order, carrying
// line_end (one past the line's last word), last_line and overflow.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 page_width,
// index 1 space_width; other indexes are ignored. Write only while idle.
// Sequence: a non-final word is simply stored. On the final word a setup
// state runs, then the solver walks backward over start words. Each start steps
// through memory read, length/fit, square and cost add/compare for every
// fitting candidate, then writes back; an overflowing candidate ends the
// scan after its read and length/fit steps. One 16x16 multiplier and one cost
// adder serve every candidate. Traceback then reads the choice store, works out
// the next line end and presents the line beat, which waits out any output stall.
// The block holds in_ready low from the final word until the last line beat.
// A stalled receiver just freezes the current line beat; nothing is lost.
// Reset clears the word count, the overflow flag and the state machine and
// loads page_width 480 and space_width 8. The stores need no clearing pass.
module line_break_dp_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lbd_pkg::WORD_W-1:0]       word_width,
	input  logic                             last_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lbd_pkg::LINE_END_W-1:0]   line_end,
	output logic                             last_line,
	output logic                             overflow,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lbd_pkg::lbd_state_t state_q, state_d;

	// configuration
	logic [lbd_pkg::PAGE_W-1:0]  page_q;
	logic [lbd_pkg::SPACE_W-1:0] space_q;

	// paragraph control
	logic [lbd_pkg::CNT_W-1:0] count_q;
	logic                      ovf_q;
	logic [lbd_pkg::IDX_W-1:0] i_q;      // start word being solved
	logic [lbd_pkg::IDX_W-1:0] j_q;      // candidate last word
	logic [lbd_pkg::CNT_W-1:0] cur_q;    // traceback position

	// solver datapath
	logic [lbd_pkg::LEN_W-1:0]  len_q;
	logic [lbd_pkg::REM_W-1:0]  rem_q;
	logic [lbd_pkg::SQ_W-1:0]   sq_q;
	logic [lbd_pkg::COST_W-1:0] best_q;
	logic [lbd_pkg::IDX_W-1:0]  pick_q;
	logic [lbd_pkg::COST_W-1:0] cnext_q;  // cost of word i+1, fallback
	logic [lbd_pkg::CNT_W-1:0]  nxt_q;

	// stores
	logic [lbd_pkg::WIDTH_BITS-1:0] width_mem  [lbd_pkg::MAX_WORDS];
	logic [lbd_pkg::COST_W-1:0]     cost_mem   [lbd_pkg::MAX_WORDS];
	logic [lbd_pkg::IDX_W-1:0]      choice_mem [lbd_pkg::MAX_WORDS];
	logic [lbd_pkg::WIDTH_BITS-1:0] w_rd_q;
	logic [lbd_pkg::COST_W-1:0]     cost_rd_q;
	logic [lbd_pkg::IDX_W-1:0]      choice_rd_q;

	logic                           in_acc, out_acc;
	logic                           width_we;
	logic                           cost_we;
	logic [lbd_pkg::IDX_W-1:0]      cost_waddr;
	logic [lbd_pkg::COST_W-1:0]     cost_wdata;
	logic [lbd_pkg::IDX_W-1:0]      choice_wdata;
	logic [lbd_pkg::CNT_W-1:0]      last_idx;
	logic                           j_is_last, j_is_first;
	logic [lbd_pkg::LEN_W-1:0]      len_new;
	logic                           fits;
	logic [lbd_pkg::SQ_W:0]         cost_sum;
	logic [lbd_pkg::COST_W-1:0]     cand;
	logic                           no_fit;
	logic [lbd_pkg::CNT_W-1:0]      nxt_raw, nxt_fix;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;
	assign cfg_ready = 1'b1;

	assign last_idx   = count_q - lbd_pkg::CNT_W'(1);
	assign j_is_last  = (lbd_pkg::CNT_W'(j_q) == last_idx);
	assign j_is_first = (j_q == i_q);

	// line length through word j; the first word carries no leading space
	assign len_new = j_is_first ? lbd_pkg::LEN_W'(w_rd_q)
	                            : len_q + lbd_pkg::LEN_W'(space_q)
	                                    + lbd_pkg::LEN_W'(w_rd_q);
	assign fits = (len_new <= lbd_pkg::LEN_W'(page_q));

	// candidate cost, saturated; a line ending the paragraph is free
	assign cost_sum = (lbd_pkg::SQ_W + 1)'(sq_q) + (lbd_pkg::SQ_W + 1)'(cost_rd_q);
	always_comb begin
		if (j_is_last) begin
			cand = '0;
		end else if (cost_sum > (lbd_pkg::SQ_W + 1)'(lbd_pkg::COST_CAP)) begin
			cand = lbd_pkg::COST_CAP;
		end else begin
			cand = lbd_pkg::COST_W'(cost_sum);
		end
	end

	// nothing usable: word i sits alone and inherits the next word's cost
	assign no_fit = (best_q == lbd_pkg::COST_CAP);

	assign width_we = in_acc && (count_q < lbd_pkg::CNT_W'(lbd_pkg::MAX_WORDS));
	assign cost_we  = (state_q == lbd_pkg::ST_INIT) || (state_q == lbd_pkg::ST_WR);

	always_comb begin
		if (state_q == lbd_pkg::ST_INIT) begin
			cost_waddr   = last_idx[lbd_pkg::IDX_W-1:0];
			cost_wdata   = '0;
			choice_wdata = last_idx[lbd_pkg::IDX_W-1:0];
		end else begin
			cost_waddr   = i_q;
			cost_wdata   = no_fit ? cnext_q : best_q;
			choice_wdata = no_fit ? i_q : pick_q;
		end
	end

	// traceback step, clamped to stay within the paragraph
	assign nxt_raw = lbd_pkg::CNT_W'(choice_rd_q) + lbd_pkg::CNT_W'(1);
	always_comb begin
		if (nxt_raw <= cur_q) begin
			nxt_fix = cur_q + lbd_pkg::CNT_W'(1);
		end else if (nxt_raw > count_q) begin
			nxt_fix = count_q;
		end else begin
			nxt_fix = nxt_raw;
		end
	end

	assign line_end  = lbd_pkg::LINE_END_W'(nxt_q);
	assign last_line = (nxt_q == count_q);
	assign overflow  = ovf_q;

	// ---------------------------------------------------------------
	// Stores: one write and one registered read port each
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (width_we) begin
			width_mem[count_q[lbd_pkg::IDX_W-1:0]] <= lbd_pkg::WIDTH_BITS'(word_width);
		end
		w_rd_q <= width_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[cost_waddr] <= cost_wdata;
		end
		cost_rd_q <= cost_mem[j_q + lbd_pkg::IDX_W'(1)];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			choice_mem[cost_waddr] <= choice_wdata;
		end
		choice_rd_q <= choice_mem[cur_q[lbd_pkg::IDX_W-1:0]];
	end

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= lbd_pkg::PAGE_RESET;
			space_q <= lbd_pkg::SPACE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lbd_pkg::CFG_PAGE_WIDTH:  page_q  <= cfg_data[lbd_pkg::PAGE_W-1:0];
				lbd_pkg::CFG_SPACE_WIDTH: space_q <= cfg_data[lbd_pkg::SPACE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lbd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_acc && last_word) begin
					state_d = lbd_pkg::ST_INIT;
				end
			end
			lbd_pkg::ST_INIT: begin
				// a one-word paragraph has nothing to solve
				state_d = (count_q == lbd_pkg::CNT_W'(1)) ? lbd_pkg::ST_TRD : lbd_pkg::ST_RD;
			end
			lbd_pkg::ST_RD:  state_d = lbd_pkg::ST_LEN;
			lbd_pkg::ST_LEN: state_d = fits ? lbd_pkg::ST_SQ : lbd_pkg::ST_WR;
			lbd_pkg::ST_SQ:  state_d = lbd_pkg::ST_ACC;
			lbd_pkg::ST_ACC: state_d = j_is_last ? lbd_pkg::ST_WR : lbd_pkg::ST_RD;
			lbd_pkg::ST_WR: begin
				state_d = (i_q == '0) ? lbd_pkg::ST_TRD : lbd_pkg::ST_RD;
			end
			lbd_pkg::ST_TRD:   state_d = lbd_pkg::ST_TCALC;
			lbd_pkg::ST_TCALC: state_d = lbd_pkg::ST_OUT;
			lbd_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_acc) begin
					state_d = (nxt_q == count_q) ? lbd_pkg::ST_IDLE : lbd_pkg::ST_TRD;
				end
			end
			default: state_d = lbd_pkg::ST_IDLE;
		endcase
	end

	// counters and paragraph bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			cur_q   <= '0;
		end else begin
			case (state_q)
				lbd_pkg::ST_IDLE: begin
					if (width_we) begin
						count_q <= count_q + lbd_pkg::CNT_W'(1);
					end else if (in_acc) begin
						ovf_q <= 1'b1;
					end
				end
				lbd_pkg::ST_INIT: begin
					i_q   <= lbd_pkg::IDX_W'(count_q - lbd_pkg::CNT_W'(2));
					j_q   <= lbd_pkg::IDX_W'(count_q - lbd_pkg::CNT_W'(2));
					cur_q <= '0;
				end
				lbd_pkg::ST_ACC: begin
					if (!j_is_last) begin
						j_q <= j_q + lbd_pkg::IDX_W'(1);
					end
				end
				lbd_pkg::ST_WR: begin
					if (i_q != '0) begin
						i_q <= i_q - lbd_pkg::IDX_W'(1);
						j_q <= i_q - lbd_pkg::IDX_W'(1);
					end
				end
				lbd_pkg::ST_OUT: begin
					if (out_acc) begin
						cur_q <= nxt_q;
						if (nxt_q == count_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// shared length / square / cost datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lbd_pkg::ST_LEN: begin
				if (j_is_first) begin
					best_q  <= lbd_pkg::COST_CAP;
					pick_q  <= i_q;
					cnext_q <= cost_rd_q;
				end
				len_q <= len_new;
				rem_q <= lbd_pkg::REM_W'(lbd_pkg::LEN_W'(page_q) - len_new);
			end
			lbd_pkg::ST_SQ: begin
				sq_q <= lbd_pkg::SQ_W'(rem_q) * lbd_pkg::SQ_W'(rem_q);
			end
			lbd_pkg::ST_ACC: begin
				// strict compare: ties keep the shorter line
				if (cand < best_q) begin
					best_q <= cand;
					pick_q <= j_q;
				end
			end
			lbd_pkg::ST_TCALC: begin
				nxt_q <= nxt_fix;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/lbd_checker.sv =====
`include "line_break_dp_unit_macros.svh"

module lbd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            last_word,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [lbd_pkg::LINE_END_W-1:0]  line_end,
	input logic                            last_line,
	input logic                            overflow
);

	logic out_stall, in_mid_word, out_done;

	assign out_stall   = out_valid && !out_ready;
	assign in_mid_word = in_valid && in_ready && !last_word;
	assign out_done    = out_valid && out_ready && last_line;

	// stalled line beat holds
	`LBD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(line_end) && $stable(last_line) && $stable(overflow), "line beat changed under stall")

	// no word taken while lines are being sent
	`LBD_ASSERT_NOW(a_busy_out, out_valid, !in_ready, "input ready while emitting lines")

	// after a plain word the block is still ready for input
	`LBD_ASSERT_NEXT(a_word_1cyc, in_mid_word, in_ready && !out_valid, "not ready after plain word")

	// closing line returns the block to idle
	`LBD_ASSERT_NEXT(a_back_idle, out_done, in_ready, "not idle after last line")

	// every line ends past word zero
	`LBD_ASSERT_NOW(a_end_nonzero, out_valid, line_end != '0, "line end is zero")

endmodule

bind line_break_dp_unit lbd_checker u_lbd_checker (.*);
